// ===== rtl/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

    localparam int DEPTH       = 16;
    localparam int KEY_W       = 16;
    localparam int DATA_W      = 32;
    localparam int OP_W        = 2;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int ENTRY_W     = KEY_W + DATA_W;
    localparam int IN_TDATA_W  = ((ENTRY_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((ENTRY_W + 2 + CNT_W + 1 + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_POP    = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
        status_t           status;
        logic [CNT_W-1:0]  count;
        logic              empty;
    } result_t;

    typedef struct packed {
        logic               rd_en;
        logic [ADDR_W-1:0]  rd_addr;
        logic               wr_en;
        logic [ADDR_W-1:0]  wr_addr;
        logic [ENTRY_W-1:0] wr_data;
    } ram_req_t;

endpackage

`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
// Bounded priority queue of up to DEPTH (priority, payload) entries held in
// order in a small entry memory, slot 0 being the head. Each input item
// carries an operation in s_tuser (append at the tail, insert in priority
// order, pop the head) and gives exactly one result item with the popped
// entry, a status, the entry count and an empty flag. Adding to a full queue
// or popping an empty one changes nothing and is reported in the status. The
// block works on one item at a time. Every entry that the insert scan
// compares or that a move shifts costs one memory read.
// An insert scans from the head until it finds its place and then shifts the
// entries behind it up by one slot; a pop shifts all remaining entries down.
// The slowest item is an insert into a queue holding DEPTH-1 entries, which
// touches every slot. Appends skip the scan, and refused operations and the
// unused opcode go straight to the result. The result sits in an output
// register, so a new item is accepted while the previous result waits.
// The entry memory needs no clearing after reset: only slots below the count
// are ever read.
`default_nettype none

module sorted_priority_queue (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Input item.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // s_tdata, lowest bit first: item_priority, item_payload.
    input  wire logic [spq_pkg::IN_TDATA_W-1:0]      s_tdata,
    // s_tuser: opcode.
    input  wire logic [spq_pkg::OP_W-1:0]            s_tuser,
    // Result item.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // m_tdata, lowest bit first: out_priority, out_payload, status,
    // entry_count, is_empty, then zero padding.
    output logic      [spq_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    import spq_pkg::*;

    result_t                res;
    logic                   res_valid;
    logic                   res_ready;
    ram_req_t               ram_req;
    logic [ENTRY_W-1:0]     ram_rd_data;

    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    // The sequencer may hand over a finished result whenever the output
    // register is empty or is being emptied in this cycle.
    assign res_ready = !m_tvalid_reg || m_tready;

    spq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (s_tuser),
        .in_key      (s_tdata[KEY_W-1:0]),
        .in_data     (s_tdata[ENTRY_W-1:KEY_W]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data)
    );

    // Entry store, packed with the payload above the priority.
    spq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rd_data)
    );

    // Output register: loaded when the sequencer finishes an item, held until
    // the downstream side takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_tdata_reg <= OUT_TDATA_W'({res.empty, res.count, res.status,
                                         res.data, res.key});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ===== rtl/spq_ram.sv =====
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/spq_ctrl.sv =====
`default_nettype none

module spq_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [spq_pkg::OP_W-1:0]   in_op,
    input  wire logic [spq_pkg::KEY_W-1:0]  in_key,
    input  wire logic [spq_pkg::DATA_W-1:0] in_data,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output spq_pkg::result_t                res,
    output spq_pkg::ram_req_t               ram_req,
    input  wire logic [spq_pkg::ENTRY_W-1:0] ram_rd_data
);

    import spq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_UP_RD,
        S_UP_WR,
        S_PUT,
        S_POP_RD,
        S_POP_CAP,
        S_DN_RD,
        S_DN_WR,
        S_DONE
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   cur_reg;
    logic [CNT_W-1:0]   pos_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [DATA_W-1:0]  data_reg;
    logic [KEY_W-1:0]   res_key_reg;
    logic [DATA_W-1:0]  res_data_reg;
    status_t            status_reg;

    logic [CNT_W-1:0]   cur_dec;
    logic [CNT_W-1:0]   cur_inc;
    logic [KEY_W-1:0]   rd_key;
    logic [DATA_W-1:0]  rd_payload;
    logic               full;
    logic               hit;

    assign cur_dec    = cur_reg - 1'b1;
    assign cur_inc    = cur_reg + 1'b1;
    assign rd_key     = ram_rd_data[KEY_W-1:0];
    assign rd_payload = ram_rd_data[ENTRY_W-1:KEY_W];
    assign full       = (count_reg == CNT_W'(DEPTH));

    // The shared comparator: the head is passed only by a strictly greater
    // key, any later entry by one that is not smaller.
    assign hit = (cur_reg == '0) ? (key_reg > rd_key) : (rd_key <= key_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res.key    = res_key_reg;
        res.data   = res_data_reg;
        res.status = status_reg;
        res.count  = count_reg;
        res.empty  = (count_reg == '0);
    end

    always_comb
    begin
        ram_req = '0;
        case (state_reg)
            S_SCAN_RD:
            begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = cur_reg[ADDR_W-1:0];
            end
            S_UP_RD:
            begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = cur_dec[ADDR_W-1:0];
            end
            S_UP_WR:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = cur_reg[ADDR_W-1:0];
                ram_req.wr_data = ram_rd_data;
            end
            S_PUT:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = pos_reg[ADDR_W-1:0];
                ram_req.wr_data = {data_reg, key_reg};
            end
            S_POP_RD:
            begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = '0;
            end
            S_DN_RD:
            begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = cur_reg[ADDR_W-1:0];
            end
            S_DN_WR:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = cur_dec[ADDR_W-1:0];
                ram_req.wr_data = ram_rd_data;
            end
            default:
            begin
                ram_req = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        key_reg      <= in_key;
                        data_reg     <= in_data;
                        res_key_reg  <= '0;
                        res_data_reg <= '0;
                        status_reg   <= ST_DONE;
                        pos_reg      <= count_reg;
                        cur_reg      <= '0;
                        case (in_op)
                            OP_APPEND:
                            begin
                                if (full)
                                begin
                                    status_reg <= ST_FULL;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    state_reg <= S_PUT;
                                end
                            end
                            OP_INSERT:
                            begin
                                if (full)
                                begin
                                    status_reg <= ST_FULL;
                                    state_reg  <= S_DONE;
                                end
                                else if (count_reg == '0)
                                begin
                                    state_reg <= S_PUT;
                                end
                                else
                                begin
                                    state_reg <= S_SCAN_RD;
                                end
                            end
                            OP_POP:
                            begin
                                if (count_reg == '0)
                                begin
                                    status_reg <= ST_EMPTY;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    state_reg <= S_POP_RD;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_CMP;
                end
                S_SCAN_CMP:
                begin
                    if (hit)
                    begin
                        pos_reg   <= cur_reg;
                        cur_reg   <= count_reg;
                        state_reg <= S_UP_RD;
                    end
                    else if (cur_inc == count_reg)
                    begin
                        pos_reg   <= count_reg;
                        state_reg <= S_PUT;
                    end
                    else
                    begin
                        cur_reg   <= cur_inc;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_UP_RD:
                begin
                    state_reg <= S_UP_WR;
                end
                S_UP_WR:
                begin
                    cur_reg <= cur_dec;
                    if (cur_dec == pos_reg)
                    begin
                        state_reg <= S_PUT;
                    end
                    else
                    begin
                        state_reg <= S_UP_RD;
                    end
                end
                S_PUT:
                begin
                    count_reg <= count_reg + 1'b1;
                    state_reg <= S_DONE;
                end
                S_POP_RD:
                begin
                    state_reg <= S_POP_CAP;
                end
                S_POP_CAP:
                begin
                    res_key_reg  <= rd_key;
                    res_data_reg <= rd_payload;
                    cur_reg      <= CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        count_reg <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_DN_RD;
                    end
                end
                S_DN_RD:
                begin
                    state_reg <= S_DN_WR;
                end
                S_DN_WR:
                begin
                    if (cur_inc == count_reg)
                    begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        cur_reg   <= cur_inc;
                        state_reg <= S_DN_RD;
                    end
                end
                S_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/spq_checker.sv =====
`default_nettype none

module spq_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [spq_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire logic [spq_pkg::OP_W-1:0]        s_tuser,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [spq_pkg::OUT_TDATA_W-1:0] m_tdata
);

    import spq_pkg::*;

    localparam int ST_LO  = ENTRY_W;
    localparam int CNT_LO = ENTRY_W + 2;
    localparam int EMP_B  = ENTRY_W + 2 + CNT_W;

    logic [KEY_W-1:0]  o_key;
    logic [DATA_W-1:0] o_data;
    logic [1:0]        o_status;
    logic [CNT_W-1:0]  o_count;
    logic              o_empty;

    assign o_key    = m_tdata[KEY_W-1:0];
    assign o_data   = m_tdata[ENTRY_W-1:KEY_W];
    assign o_status = m_tdata[ST_LO+1:ST_LO];
    assign o_count  = m_tdata[CNT_LO+CNT_W-1:CNT_LO];
    assign o_empty  = m_tdata[EMP_B];

    // Each item keeps the sequencer busy, so the input is never ready in the cycle after an accepted item.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted in two consecutive cycles");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or vanished");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> o_count <= CNT_W'(DEPTH))
        else $error("entry count beyond queue depth");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> o_empty == (o_count == '0))
        else $error("empty flag disagrees with entry count");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && o_status != ST_DONE |-> o_key == '0 && o_data == '0)
        else $error("refused operation returned an entry");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

`default_nettype wire

// ===== sim/tb_sorted_priority_queue.sv =====
module tb_sorted_priority_queue;
    import spq_pkg::*;

    // Opcode value that the block must treat as a no-op with status done.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Generous cycle budget: besides the slowest operations it must cover sender
    // gaps, receiver stalls and the long hold-off.
    localparam int CYCLE_LIMIT  = 300000;
    // Cycles allowed after the last expected result has arrived, so that any
    // stray result item still has time to show up and be flagged.
    localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
    localparam int RANDOM_ITEMS = 524;
    // The receiver holds off once for this many cycles after HOLD_AT results.
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AT      = 120;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
    } queue_request_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // s_tdata, lowest bit first: item_priority, item_payload.
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    // s_tuser: opcode.
    logic [OP_W-1:0]        s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // m_tdata, lowest bit first: out_priority, out_payload, status,
    // entry_count, is_empty, then zero padding.
    logic [OUT_TDATA_W-1:0] m_tdata;

    sorted_priority_queue dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Items waiting to be offered, and the results predicted for accepted items,
    // oldest first.
    queue_request_t pending[$];
    result_t        expected_results[$];

    // Our own copy of the queue contents, slot 0 being the head.
    logic [KEY_W-1:0]  model_key  [DEPTH];
    logic [DATA_W-1:0] model_data [DEPTH];
    int                model_len = 0;

    // Tallies for the closing summary.
    int n_append = 0;
    int n_insert = 0;
    int n_pop = 0;
    int n_unused = 0;
    int n_full_refused = 0;
    int n_empty_refused = 0;
    int peak_len = 0;
    int results_seen = 0;
    int mismatches = 0;
    int cycle_count = 0;

    // Applies one operation to the queue copy and returns the result item that
    // the block should produce for it.
    function automatic result_t apply_queue_op(input logic [OP_W-1:0]   op,
                                               input logic [KEY_W-1:0]  key,
                                               input logic [DATA_W-1:0] data);
        result_t r;
        int      pos;
        int      i;
        r = '0;
        r.status = ST_DONE;
        if (op == OP_APPEND || op == OP_INSERT)
        begin
            if (op == OP_APPEND)
                n_append++;
            else
                n_insert++;
            if (model_len >= DEPTH)
            begin
                r.status = ST_FULL;
                n_full_refused++;
            end
            else
            begin
                pos = model_len;
                if (op == OP_INSERT)
                begin
                    // The head is only displaced by a strictly greater priority.
                    // Behind the head the entry goes before the first slot whose
                    // priority is not greater, taken literally even when appends
                    // have left the store out of order.
                    if (model_len == 0 || key > model_key[0])
                    begin
                        pos = 0;
                    end
                    else
                    begin
                        for (i = model_len - 1; i >= 1; i--)
                        begin
                            if (model_key[i] <= key)
                                pos = i;
                        end
                    end
                end
                for (i = model_len; i > pos; i--)
                begin
                    model_key[i]  = model_key[i-1];
                    model_data[i] = model_data[i-1];
                end
                model_key[pos]  = key;
                model_data[pos] = data;
                model_len++;
                if (model_len > peak_len)
                    peak_len = model_len;
            end
        end
        else if (op == OP_POP)
        begin
            n_pop++;
            if (model_len == 0)
            begin
                r.status = ST_EMPTY;
                n_empty_refused++;
            end
            else
            begin
                r.key  = model_key[0];
                r.data = model_data[0];
                for (i = 1; i < model_len; i++)
                begin
                    model_key[i-1]  = model_key[i];
                    model_data[i-1] = model_data[i];
                end
                model_len--;
            end
        end
        else
        begin
            n_unused++;
        end
        r.count = model_len[CNT_W-1:0];
        r.empty = (model_len == 0);
        return r;
    endfunction

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Sender. Items go out in bursts of random length separated by random
    // gaps; a gap of zero joins two bursts, which gives stretches without any
    // idling. An offered item is held unchanged until the block takes it.
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                void'(pending.pop_front());
            if (s_tvalid && !s_tready)
            begin
                // Still waiting for the block to take the current item.
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tuser <= pending[0].op;
                s_tdata <= {pending[0].data, pending[0].key};
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(0, 7);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Every accepted item is run through the predictor at the edge where the
    // handshake completes.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            expected_results.push_back(apply_queue_op(s_tuser, s_tdata[KEY_W-1:0],
                                                      s_tdata[KEY_W +: DATA_W]));
    end

    // Receiver. Its readiness follows a randomly redrawn mode:
    // always ready, random, mostly stalled, or a slow square wave. Once, after
    // HOLD_AT results, it holds off so that the output register stays full and
    // the block has to stall its input.
    int  rx_tick;
    int  rx_mode;
    int  hold_left;
    bit  hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_tick = 0;
            rx_mode = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            rx_tick++;
            if (rx_tick % 64 == 0)
                rx_mode = $urandom_range(0, 3);
            if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 1);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ((rx_tick / 4) % 2 == 1);
                endcase
            end
        end
    end

    // Result checker: each accepted result item is compared field by field
    // with the oldest prediction.
    result_t want;
    result_t seen;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            seen.key    = m_tdata[KEY_W-1:0];
            seen.data   = m_tdata[KEY_W +: DATA_W];
            seen.status = status_t'(m_tdata[ENTRY_W +: 2]);
            seen.count  = m_tdata[ENTRY_W + 2 +: CNT_W];
            seen.empty  = m_tdata[ENTRY_W + 2 + CNT_W];
            if (expected_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("Result item %0d arrived with nothing expected: %s",
                             results_seen, "");
                if (mismatches < 10)
                    $display("  prio %h data %h status %0d count %0d empty %0d",
                             seen.key, seen.data, seen.status, seen.count,
                             seen.empty);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (seen.key !== want.key || seen.data !== want.data ||
                    seen.status !== want.status || seen.count !== want.count ||
                    seen.empty !== want.empty)
                begin
                    if (mismatches < 10)
                    begin
                        $display("Result item %0d mismatch:", results_seen);
                        $display("  expected prio %h data %h status %0d count %0d empty %0d",
                                 want.key, want.data, want.status, want.count, want.empty);
                        $display("  actual   prio %h data %h status %0d count %0d empty %0d",
                                 seen.key, seen.data, seen.status, seen.count, seen.empty);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Stimulus and end of run.
    int  n;
    int  roll;
    bit  filling;
    logic [OP_W-1:0]   r_op;
    logic [KEY_W-1:0]  r_key;
    logic [DATA_W-1:0] r_data;

    initial
    begin
        rst_n = 1'b0;

        // Directed part. A pop refused on an empty queue and the unused opcode come
        // first, then inserts that take the head, go to the tail, and meet equal
        // priorities both at the head and behind it.
        pending.push_back('{OP_POP,    16'h0000, 32'h0000_0000});
        pending.push_back('{OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF});
        pending.push_back('{OP_INSERT, 16'h8000, 32'h0000_0000});
        pending.push_back('{OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF});
        pending.push_back('{OP_INSERT, 16'h0000, 32'h1234_5678});
        pending.push_back('{OP_INSERT, 16'h8000, 32'h8000_0001});
        pending.push_back('{OP_INSERT, 16'hFFFF, 32'hFFFF_0002});
        // An append of a high priority at the tail leaves the store unsorted;
        // the following insert must still stop at the first lower slot.
        pending.push_back('{OP_APPEND, 16'hFFFF, 32'h0F0F_0F0F});
        pending.push_back('{OP_INSERT, 16'h0001, 32'hF0F0_F0F0});
        pending.push_back('{OP_POP,    16'h0000, 32'h0000_0000});
        // Fill up to DEPTH with appends of alternating bit patterns.
        for (n = 0; n < 10; n++)
            pending.push_back('{OP_APPEND, n[0] ? 16'h5555 : 16'hAAAA,
                                n[0] ? 32'h5555_5555 : 32'hAAAA_AAAA});
        // Adds to a full queue are refused, and the unused opcode is a no-op.
        pending.push_back('{OP_APPEND, 16'h1111, 32'h2222_2222});
        pending.push_back('{OP_INSERT, 16'hFFFF, 32'h3333_3333});
        pending.push_back('{OP_UNUSED, 16'h0000, 32'h0000_0000});
        pending.push_back('{OP_POP,    16'h0000, 32'h0000_0000});
        pending.push_back('{OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF});
        pending.push_back('{OP_POP,    16'h0000, 32'h0000_0000});

        // Random part in phases that alternately favour adds and pops, so the
        // queue swings between empty and full. Half the priorities come from a
        // narrow range to produce plenty of equal keys.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            filling = ((n / 48) % 2 == 0);
            roll = $urandom_range(0, 99);
            if (roll < 4)
                r_op = OP_UNUSED;
            else if (roll < (filling ? 44 : 19))
                r_op = OP_INSERT;
            else if (roll < (filling ? 70 : 30))
                r_op = OP_APPEND;
            else
                r_op = OP_POP;
            r_key = ($urandom_range(0, 1) == 1) ? KEY_W'($urandom_range(0, 15))
                                                : KEY_W'($urandom_range(0, 65535));
            r_data = $urandom();
            pending.push_back('{r_op, r_key, r_data});
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() > 0)
            @(posedge clk);
        @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_results.size() > 0)
        begin
            $display("%0d expected result items never arrived", expected_results.size());
            mismatches++;
        end

        $display("Checked %0d results: %0d appends, %0d ordered inserts, %0d pops,",
                 results_seen, n_append, n_insert, n_pop);
        $display("  %0d unused opcodes, %0d adds refused when full, %0d pops refused when empty,",
                 n_unused, n_full_refused, n_empty_refused);
        $display("  peak occupancy %0d, mismatches %0d.", peak_len, mismatches);
        if (mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/spq_pkg.sv
rtl/spq_ram.sv
rtl/spq_ctrl.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
sim/tb_sorted_priority_queue.sv
